// ===== rtl/led_fire_heat_effect_macros.svh =====
// Assertion macros for the checker file of the fire heat effect block.
`ifndef LED_FIRE_HEAT_EFFECT_MACROS_SVH
`define LED_FIRE_HEAT_EFFECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfhe_pkg.sv =====
// Package with the shared types, constants and helper function of the fire heat effect.
package lfhe_pkg;

  localparam int NUM_CELLS = 64;
  localparam int CELL_W    = $clog2(NUM_CELLS);

  typedef logic [CELL_W-1:0] cell_addr_t;

  localparam cell_addr_t LAST_CELL = cell_addr_t'(NUM_CELLS - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COOL_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARK_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 2'd2;

  localparam logic [7:0]  COOL_LIMIT_RST   = 8'd10;
  localparam logic [7:0]  SPARK_THRESH_RST = 8'd120;
  localparam logic [15:0] NOISE_SEED_RST   = 16'd44257;

  // Arithmetic constants of the shared unit.
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int         DIV3_SHIFT = 11;
  localparam logic [9:0] SHADE_MUL  = 10'd191;
  localparam logic [15:0] SHADE_BIAS = 16'd127;
  localparam logic [7:0] TOP_BAND   = 8'h80;
  localparam logic [7:0] MID_BAND   = 8'h40;
  localparam logic [7:0] FULL_LEVEL = 8'hFF;

  typedef enum logic [1:0] {
    OP_COOL,
    OP_DIFF,
    OP_SHADE
  } alu_op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       rd_en;
    cell_addr_t rd_addr;
    logic       wr_en;
    cell_addr_t wr_addr;
    logic [7:0] wr_data;
  } ram_req_t;

  // Fibonacci LFSR with taps 16, 14, 13 and 11.
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[15:1]};
  endfunction

endpackage

// ===== rtl/lfhe_ifs.sv =====
// Valid/ready channel interfaces for frame requests and colour results.
interface lfhe_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] spark_roll;
  logic [2:0] spark_cell;
  logic [7:0] spark_boost;

  modport source (output valid, output spark_roll, output spark_cell, output spark_boost,
                  input ready);
  modport sink (input valid, input spark_roll, input spark_cell, input spark_boost,
                output ready);
endinterface

interface lfhe_pix_if;
  logic       valid;
  logic       ready;
  logic [5:0] cell_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_last;

  modport source (output valid, output cell_index, output red, output green, output blue,
                  output frame_last, input ready);
  modport sink (input valid, input cell_index, input red, input green, input blue,
                input frame_last, output ready);
endinterface

// ===== rtl/lfhe_alu.sv =====
// Shared arithmetic unit: cooling, diffusion divide by three and heat palette lookup.
module lfhe_alu
  import lfhe_pkg::*;
(
  input  alu_op_t    op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] c,
  output logic [7:0] result,
  output pixel_t     pixel
);

  logic [9:0]  mul_a;
  logic [9:0]  mul_b;
  logic [19:0] prod;
  logic [9:0]  diff_sum;
  logic [7:0]  cooldown;
  logic [7:0]  cooled;
  logic [15:0] shade_x;
  logic [15:0] shade_sum;
  logic [7:0]  shade_t;
  logic [7:0]  ramp;

  assign diff_sum = {2'b00, a} + {1'b0, b, 1'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_COOL: begin
        mul_a = {2'b00, b};
        mul_b = {2'b00, c};
      end
      OP_DIFF: begin
        mul_a = diff_sum;
        mul_b = DIV3_RECIP;
      end
      OP_SHADE: begin
        mul_a = {2'b00, a};
        mul_b = SHADE_MUL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign cooldown = prod[15:8];
  assign cooled   = (cooldown > a) ? 8'd0 : (a - cooldown);

  // Divide by 255 as (x + 1 + (x >> 8)) >> 8, exact over the range of h*191+127.
  assign shade_x   = prod[15:0] + SHADE_BIAS;
  assign shade_sum = shade_x + 16'd1 + {8'd0, shade_x[15:8]};
  assign shade_t   = shade_sum[15:8];
  assign ramp      = {shade_t[5:0], 2'b00};

  always_comb begin
    unique case (op)
      OP_COOL:  result = cooled;
      OP_DIFF:  result = 8'(prod >> DIV3_SHIFT);
      OP_SHADE: result = shade_t;
      default:  result = '0;
    endcase
  end

  always_comb begin
    priority if (shade_t > TOP_BAND) begin
      pixel = '{red: FULL_LEVEL, green: FULL_LEVEL, blue: ramp};
    end else if (shade_t > MID_BAND) begin
      pixel = '{red: FULL_LEVEL, green: ramp, blue: 8'd0};
    end else begin
      pixel = '{red: ramp, green: 8'd0, blue: 8'd0};
    end
  end

endmodule

// ===== rtl/lfhe_heat_ram.sv =====
// Heat store: one byte per cell, one write and one registered read per cycle.
module lfhe_heat_ram
  import lfhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ram_req_t   ctrl,
  output logic [7:0] rd_data
);

  logic [7:0]           mem [NUM_CELLS];
  logic [NUM_CELLS-1:0] valid;

  // A cell never written since reset reads as zero heat.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[ctrl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= valid[ctrl.rd_addr] ? mem[ctrl.rd_addr] : 8'd0;
    end
  end

endmodule

// ===== rtl/led_fire_heat_effect.sv =====
// Top level of the fire heat effect: sequencer, configuration registers and result register.
//
//   channel  dir  beat contents
//   req      in   spark_roll, spark_cell, spark_boost (one frame request)
//   pix      out  cell_index, red, green, blue, frame_last (one colour per cell)
//   cfg_*    in   cfg_we, cfg_index, cfg_data (register write, no handshake)
//
// A frame runs from one req beat to the next through a cooling pass over every cell, a
// prime step for the diffusion, a diffusion pass from the top cell down to cell 2, an
// emit pass over every cell and the idle state that takes req.
// The heat store gives one read and one write a cycle, so each pass moves one cell a cycle.
// Reset is synchronous and clears the heat store valid bits at once; no clearing pass.
// A stalled pix beat holds the emit pass; req is ready again once the top cell is loaded.
module led_fire_heat_effect
  import lfhe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lfhe_req_if.sink              req,
  lfhe_pix_if.source            pix
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_COOL  = 5'b00010,
    ST_PRIME = 5'b00100,
    ST_DIFF  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  cell_addr_t idx;
  cell_addr_t idx_next;
  logic [7:0] prev;
  logic [15:0] lfsr;
  logic [15:0] lfsr_step;
  logic        step_lfsr;
  logic [7:0]  cool_limit;
  logic [7:0]  spark_threshold;
  logic        fire;
  logic [2:0]  spark_cell;
  logic [7:0]  spark_boost;

  ram_req_t   ram_ctrl;
  logic [7:0] rd_data;

  alu_op_t    alu_op;
  logic [7:0] alu_a;
  logic [7:0] alu_b;
  logic [7:0] alu_result;
  pixel_t     alu_pixel;

  logic       req_accept;
  logic       slot_free;
  logic       load_pix;
  logic       spark_hit;
  logic [7:0] emit_heat;

  logic       pix_valid;
  logic [5:0] pix_index;
  pixel_t     pix_pixel;
  logic       pix_last;

  assign req.ready  = (state == ST_IDLE);
  assign req_accept = req.valid && req.ready;
  assign slot_free  = !pix_valid || pix.ready;
  assign lfsr_step  = lfsr_next(lfsr);

  // The spark lands after diffusion, so it is folded in as the cell is emitted.
  assign spark_hit = fire && (idx == cell_addr_t'(spark_cell));
  assign emit_heat = spark_hit ? (rd_data + spark_boost) : rd_data;

  always_comb begin
    alu_a = emit_heat;
    alu_b = rd_data;
    unique case (state)
      ST_COOL: begin
        alu_op = OP_COOL;
        alu_a  = rd_data;
        alu_b  = lfsr_step[7:0];
      end
      ST_DIFF: begin
        alu_op = OP_DIFF;
        alu_a  = prev;
        alu_b  = rd_data;
      end
      default: alu_op = OP_SHADE;
    endcase
  end

  lfhe_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .c      (cool_limit),
    .result (alu_result),
    .pixel  (alu_pixel)
  );

  lfhe_heat_ram u_heat_ram (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ram_ctrl),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ram_ctrl   = '0;
    load_pix   = 1'b0;
    step_lfsr  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          ram_ctrl.rd_en   = 1'b1;
          ram_ctrl.rd_addr = '0;
          idx_next         = '0;
          state_next       = ST_COOL;
        end
      end
      ST_COOL: begin
        ram_ctrl.wr_en   = 1'b1;
        ram_ctrl.wr_addr = idx;
        ram_ctrl.wr_data = alu_result;
        ram_ctrl.rd_en   = 1'b1;
        step_lfsr        = 1'b1;
        if (idx == LAST_CELL) begin
          ram_ctrl.rd_addr = LAST_CELL - cell_addr_t'(1);
          state_next       = ST_PRIME;
        end else begin
          ram_ctrl.rd_addr = idx + cell_addr_t'(1);
          idx_next         = idx + cell_addr_t'(1);
        end
      end
      ST_PRIME: begin
        ram_ctrl.rd_en   = 1'b1;
        ram_ctrl.rd_addr = LAST_CELL - cell_addr_t'(2);
        idx_next         = LAST_CELL;
        state_next       = ST_DIFF;
      end
      ST_DIFF: begin
        // Top down: cells below idx still hold their cooled values.
        ram_ctrl.wr_en   = 1'b1;
        ram_ctrl.wr_addr = idx;
        ram_ctrl.wr_data = alu_result;
        ram_ctrl.rd_en   = 1'b1;
        if (idx == cell_addr_t'(2)) begin
          ram_ctrl.rd_addr = '0;
          idx_next         = '0;
          state_next       = ST_EMIT;
        end else begin
          ram_ctrl.rd_addr = idx - cell_addr_t'(3);
          idx_next         = idx - cell_addr_t'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_pix         = 1'b1;
          ram_ctrl.wr_en   = spark_hit;
          ram_ctrl.wr_addr = idx;
          ram_ctrl.wr_data = emit_heat;
          if (idx == LAST_CELL) begin
            state_next = ST_IDLE;
          end else begin
            ram_ctrl.rd_en   = 1'b1;
            ram_ctrl.rd_addr = idx + cell_addr_t'(1);
            idx_next         = idx + cell_addr_t'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      idx             <= '0;
      lfsr            <= NOISE_SEED_RST;
      cool_limit      <= COOL_LIMIT_RST;
      spark_threshold <= SPARK_THRESH_RST;
      pix_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      pix_valid <= load_pix || (pix_valid && !pix.ready);
      if (step_lfsr) begin
        lfsr <= lfsr_step;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COOL_LIMIT:   cool_limit      <= cfg_data[7:0];
          REG_SPARK_THRESH: spark_threshold <= cfg_data[7:0];
          REG_NOISE_SEED:   lfsr            <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      fire        <= (req.spark_roll < spark_threshold);
      spark_cell  <= req.spark_cell;
      spark_boost <= req.spark_boost;
    end
    if (state == ST_PRIME || state == ST_DIFF) begin
      prev <= rd_data;
    end
    if (load_pix) begin
      pix_index <= 6'(idx);
      pix_pixel <= alu_pixel;
      pix_last  <= (idx == LAST_CELL);
    end
  end

  assign pix.valid      = pix_valid;
  assign pix.cell_index = pix_index;
  assign pix.red        = pix_pixel.red;
  assign pix.green      = pix_pixel.green;
  assign pix.blue       = pix_pixel.blue;
  assign pix.frame_last = pix_last;

endmodule

// ===== rtl/lfhe_checker.sv =====
// Port-level assertions for the fire heat effect and the bind that attaches them.
`include "led_fire_heat_effect_macros.svh"

module lfhe_checker
  import lfhe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       pix_valid,
  input logic       pix_ready,
  input logic [5:0] pix_cell_index,
  input logic [7:0] pix_red,
  input logic [7:0] pix_green,
  input logic [7:0] pix_blue,
  input logic       pix_frame_last
);

  // The frame end mark sits on the top cell and nowhere else.
  `LFHE_ASSERT_NOW(a_last_on_top_cell, pix_valid, pix_frame_last == (pix_cell_index == 6'(NUM_CELLS - 1)), "frame_last does not match the top cell")

  // An accepted request keeps the block busy for the frame.
  `LFHE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken again right after a request beat")

  // Once idle, the only beat that may still wait is the last one of the frame.
  `LFHE_ASSERT_NOW(a_idle_only_tail, req_ready && pix_valid, pix_frame_last, "block idle while a frame is only partly emitted")

  // A stalled result beat holds.
  `LFHE_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable({pix_cell_index, pix_red, pix_green, pix_blue, pix_frame_last}), "stalled pix beat changed")

endmodule

bind led_fire_heat_effect lfhe_checker u_lfhe_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .pix_valid      (pix.valid),
  .pix_ready      (pix.ready),
  .pix_cell_index (pix.cell_index),
  .pix_red        (pix.red),
  .pix_green      (pix.green),
  .pix_blue       (pix.blue),
  .pix_frame_last (pix.frame_last)
);
